### hdl/ptw_pkg.sv
// Shared types and constants for the paged text tile writer.
`default_nettype none

package ptw_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_CHAR   = 2'd1,
    OP_TICK   = 2'd2,
    OP_SELECT = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_WRITING = 4'b0010,
    ST_WAITING = 4'b0100,
    ST_FINAL   = 4'b1000
  } mode_state_t;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_WRITING = 2'd1;
  localparam logic [1:0] MODE_WAITING = 2'd2;
  localparam logic [1:0] MODE_FINAL   = 2'd3;

  localparam logic [1:0] REG_LINES_PER_PAGE = 2'd0;
  localparam logic [1:0] REG_GLYPH_OFFSET   = 2'd1;
  localparam logic [1:0] REG_ARROW_COLUMN   = 2'd2;
  localparam logic [1:0] REG_BORDER_TILE    = 2'd3;

  localparam logic [7:0] CH_NEWLINE       = 8'd10;
  localparam logic [7:0] CH_END           = 8'd0;
  localparam logic [7:0] CH_ARROW         = 8'd60;
  localparam logic [3:0] BLINK_ON_FRAME   = 4'd0;
  localparam logic [3:0] BLINK_OFF_FRAME  = 4'd8;
  localparam logic [7:0] ARROW_ROW_OFFSET = 8'd3;
  localparam logic [7:0] ROW_STEP         = 8'd2;

  localparam logic [7:0] LINES_PER_PAGE_RST = 8'd2;
  localparam logic [7:0] GLYPH_OFFSET_RST   = 8'd0;
  localparam logic [7:0] ARROW_COLUMN_RST   = 8'd15;
  localparam logic [7:0] BORDER_TILE_RST    = 8'd0;

  typedef struct packed {
    logic [7:0] lines_per_page;
    logic [7:0] glyph_offset;
    logic [7:0] arrow_column;
    logic [7:0] border_tile;
  } cfg_t;

  typedef struct packed {
    mode_state_t mode;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
    logic [7:0]  root_col;
    logic [7:0]  root_row;
    logic [7:0]  line_count;
    logic [3:0]  blink_frame;
    logic        end_wait_flag;
  } state_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] char_code;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic       wait_at_end;
  } item_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] tile_x;
    logic [7:0] tile_y;
    logic [7:0] tile_index;
    logic       clear_box;
    logic       accepted;
    logic [1:0] mode;
  } result_t;

endpackage

`default_nettype wire

### hdl/ptw_step.sv
// Next-state and result logic for one item of the tile writer.
`default_nettype none

module ptw_step (
  input  wire ptw_pkg::cfg_t    cfg,
  input  wire ptw_pkg::state_t  state,
  input  wire ptw_pkg::item_t   item,
  output ptw_pkg::state_t       state_next,
  output ptw_pkg::result_t      result
);

  logic [7:0] line_inc;
  logic [3:0] frame_inc;

  assign line_inc  = state.line_count + 8'd1;
  assign frame_inc = state.blink_frame + 4'd1;

  always_comb begin
    state_next = state;
    result     = '0;
    result.accepted = 1'b1;

    case (item.operation)
      ptw_pkg::OP_BEGIN: begin
        state_next.root_col      = item.start_x;
        state_next.root_row      = item.start_y;
        state_next.cursor_col    = item.start_x;
        state_next.cursor_row    = item.start_y;
        state_next.end_wait_flag = item.wait_at_end;
        state_next.line_count    = 8'd0;
        state_next.mode          = ptw_pkg::ST_WRITING;
        result.clear_box         = 1'b1;
      end
      ptw_pkg::OP_CHAR: begin
        if (state.mode != ptw_pkg::ST_WRITING) begin
          result.accepted = 1'b0;
        end else if (item.char_code == ptw_pkg::CH_NEWLINE) begin
          state_next.cursor_col = state.root_col;
          if (line_inc >= cfg.lines_per_page) begin
            // page full: back to the root row and wait for a key
            state_next.line_count = 8'd0;
            state_next.cursor_row = state.root_row;
            state_next.mode       = ptw_pkg::ST_WAITING;
          end else begin
            state_next.line_count = line_inc;
            state_next.cursor_row = state.cursor_row + ptw_pkg::ROW_STEP;
          end
        end else if (item.char_code == ptw_pkg::CH_END) begin
          state_next.line_count = 8'd0;
          state_next.mode = state.end_wait_flag ? ptw_pkg::ST_FINAL : ptw_pkg::ST_IDLE;
        end else begin
          result.write_valid    = 1'b1;
          result.tile_x         = state.cursor_col;
          result.tile_y         = state.cursor_row;
          result.tile_index     = item.char_code - cfg.glyph_offset;
          state_next.cursor_col = state.cursor_col + 8'd1;
        end
      end
      ptw_pkg::OP_TICK: begin
        if (state.mode == ptw_pkg::ST_WAITING) begin
          state_next.blink_frame = frame_inc;
          if (frame_inc == ptw_pkg::BLINK_ON_FRAME ||
              frame_inc == ptw_pkg::BLINK_OFF_FRAME) begin
            result.write_valid = 1'b1;
            result.tile_x      = state.root_col + cfg.arrow_column;
            result.tile_y      = state.root_row + ptw_pkg::ARROW_ROW_OFFSET;
            result.tile_index  = (frame_inc == ptw_pkg::BLINK_ON_FRAME) ?
                                 (ptw_pkg::CH_ARROW - cfg.glyph_offset) :
                                 cfg.border_tile;
          end
        end
      end
      default: begin
        if (state.mode == ptw_pkg::ST_WAITING) begin
          state_next.mode  = ptw_pkg::ST_WRITING;
          result.clear_box = 1'b1;
        end else if (state.mode == ptw_pkg::ST_FINAL) begin
          state_next.mode = ptw_pkg::ST_IDLE;
        end
      end
    endcase

    case (state_next.mode)
      ptw_pkg::ST_IDLE:    result.mode = ptw_pkg::MODE_IDLE;
      ptw_pkg::ST_WRITING: result.mode = ptw_pkg::MODE_WRITING;
      ptw_pkg::ST_WAITING: result.mode = ptw_pkg::MODE_WAITING;
      ptw_pkg::ST_FINAL:   result.mode = ptw_pkg::MODE_FINAL;
      default:             result.mode = ptw_pkg::MODE_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/paged_text_tile_writer.sv
// Top level of the paged text tile writer: input register, step logic, result register.
`default_nettype none

// Takes one item (begin, character, frame tick or select press) per cycle and
// returns exactly one result per item: an optional tile write, a box-clear
// request, the accept flag for characters and the mode after the item. An
// item is held in the input register, then the step logic updates the text
// state and loads the result register; throughput is one item per cycle
// while the output side keeps taking results. Configuration writes (index 0
// lines_per_page, 1 glyph_offset, 2 arrow_column, 3 border_tile) are always
// taken; other indexes are dropped.
module paged_text_tile_writer (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [7:0]  cfg_index,
  input  wire [7:0]  cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [1:0]  operation,
  input  wire [7:0]  char_code,
  input  wire [7:0]  start_x,
  input  wire [7:0]  start_y,
  input  wire        wait_at_end,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       write_valid,
  output logic [7:0] tile_x,
  output logic [7:0] tile_y,
  output logic [7:0] tile_index,
  output logic       clear_box,
  output logic       accepted,
  output logic [1:0] mode
);

  ptw_pkg::cfg_t    cfg;
  ptw_pkg::state_t  state;
  ptw_pkg::state_t  state_next;
  ptw_pkg::item_t   item;
  ptw_pkg::result_t step_result;
  ptw_pkg::result_t result;
  logic             item_valid;
  logic             advance;

  assign cfg_ready = 1'b1;

  // an item moves on when the result register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lines_per_page <= ptw_pkg::LINES_PER_PAGE_RST;
      cfg.glyph_offset   <= ptw_pkg::GLYPH_OFFSET_RST;
      cfg.arrow_column   <= ptw_pkg::ARROW_COLUMN_RST;
      cfg.border_tile    <= ptw_pkg::BORDER_TILE_RST;
    end else if (cfg_valid && cfg_index[7:2] == 6'd0) begin
      case (cfg_index[1:0])
        ptw_pkg::REG_LINES_PER_PAGE: cfg.lines_per_page <= cfg_data;
        ptw_pkg::REG_GLYPH_OFFSET:   cfg.glyph_offset   <= cfg_data;
        ptw_pkg::REG_ARROW_COLUMN:   cfg.arrow_column   <= cfg_data;
        ptw_pkg::REG_BORDER_TILE:    cfg.border_tile    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.operation   <= ptw_pkg::op_t'(operation);
      item.char_code   <= char_code;
      item.start_x     <= start_x;
      item.start_y     <= start_y;
      item.wait_at_end <= wait_at_end;
    end
  end

  ptw_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= ptw_pkg::ST_IDLE;
      state.cursor_col    <= 8'd0;
      state.cursor_row    <= 8'd0;
      state.root_col      <= 8'd0;
      state.root_row      <= 8'd0;
      state.line_count    <= 8'd0;
      state.blink_frame   <= 4'd0;
      state.end_wait_flag <= 1'b0;
    end else if (item_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      result <= step_result;
    end
  end

  assign write_valid = result.write_valid;
  assign tile_x      = result.tile_x;
  assign tile_y      = result.tile_y;
  assign tile_index  = result.tile_index;
  assign clear_box   = result.clear_box;
  assign accepted    = result.accepted;
  assign mode        = result.mode;

endmodule

`default_nettype wire

### test/tb_paged_text_tile_writer.sv
// Testbench for the paged text tile writer: directed and random text streams checked against a predictor.
`default_nettype none

module tb_paged_text_tile_writer;

  localparam int RESULT_LATENCY    = 2;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int MAX_REPORTS       = 10;
  localparam logic [7:0] UNMAPPED_REG_INDEX = 8'd200;
  localparam logic [7:0] CH_LETTER_A = 8'd65;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_LIGHT,
    SINK_PERIODIC,
    SINK_HEAVY
  } sink_style_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] operation = '0;
  logic [7:0] char_code = '0;
  logic [7:0] start_x = '0;
  logic [7:0] start_y = '0;
  logic       wait_at_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       write_valid;
  logic [7:0] tile_x;
  logic [7:0] tile_y;
  logic [7:0] tile_index;
  logic       clear_box;
  logic       accepted;
  logic [1:0] mode;

  paged_text_tile_writer i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .char_code  (char_code),
    .start_x    (start_x),
    .start_y    (start_y),
    .wait_at_end(wait_at_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .write_valid(write_valid),
    .tile_x     (tile_x),
    .tile_y     (tile_y),
    .tile_index (tile_index),
    .clear_box  (clear_box),
    .accepted   (accepted),
    .mode       (mode)
  );

  always #5 clk = ~clk;

  // Shadow configuration and text state
  logic [7:0] lines_limit;
  logic [7:0] glyph_base;
  logic [7:0] arrow_col_ofs;
  logic [7:0] blank_tile;
  logic [1:0] box_mode;
  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic [7:0] home_col;
  logic [7:0] home_row;
  logic [7:0] page_lines;
  logic [3:0] blink_phase;
  logic       hold_at_end;

  ptw_pkg::result_t tile_results_due[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int writes_seen = 0;
  int clears_seen = 0;
  int refusals_seen = 0;
  int burst_left = 0;
  bit steady_feed = 1'b0;
  bit feeding = 1'b0;

  sink_style_t sink_style = SINK_ALWAYS;
  logic        out_hold = 1'b0;
  logic [7:0]  sink_tick = '0;
  event        long_stall_go;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // Compute the result of one item and advance the shadow state.
  function automatic ptw_pkg::result_t step_text_box(ptw_pkg::item_t it);
    ptw_pkg::result_t r;
    r = '0;
    r.accepted = 1'b1;
    case (it.operation)
      ptw_pkg::OP_BEGIN: begin
        home_col    = it.start_x;
        home_row    = it.start_y;
        hold_at_end = it.wait_at_end;
        cur_col     = it.start_x;
        cur_row     = it.start_y;
        page_lines  = '0;
        box_mode    = ptw_pkg::MODE_WRITING;
        r.clear_box = 1'b1;
      end
      ptw_pkg::OP_CHAR: begin
        if (box_mode != ptw_pkg::MODE_WRITING) begin
          r.accepted = 1'b0;
        end else if (it.char_code == ptw_pkg::CH_NEWLINE) begin
          cur_col    = home_col;
          cur_row    = cur_row + ptw_pkg::ROW_STEP;
          page_lines = page_lines + 8'd1;
          if (page_lines >= lines_limit) begin
            page_lines = '0;
            cur_row    = home_row;
            box_mode   = ptw_pkg::MODE_WAITING;
          end
        end else if (it.char_code == ptw_pkg::CH_END) begin
          page_lines = '0;
          box_mode   = hold_at_end ? ptw_pkg::MODE_FINAL : ptw_pkg::MODE_IDLE;
        end else begin
          r.write_valid = 1'b1;
          r.tile_x      = cur_col;
          r.tile_y      = cur_row;
          r.tile_index  = it.char_code - glyph_base;
          cur_col       = cur_col + 8'd1;
        end
      end
      ptw_pkg::OP_TICK: begin
        if (box_mode == ptw_pkg::MODE_WAITING) begin
          blink_phase = blink_phase + 4'd1;
          if (blink_phase == ptw_pkg::BLINK_ON_FRAME ||
              blink_phase == ptw_pkg::BLINK_OFF_FRAME) begin
            r.write_valid = 1'b1;
            r.tile_x      = home_col + arrow_col_ofs;
            r.tile_y      = home_row + ptw_pkg::ARROW_ROW_OFFSET;
            r.tile_index  = (blink_phase == ptw_pkg::BLINK_ON_FRAME) ?
                            ptw_pkg::CH_ARROW - glyph_base : blank_tile;
          end
        end
      end
      default: begin
        if (box_mode == ptw_pkg::MODE_WAITING) begin
          box_mode    = ptw_pkg::MODE_WRITING;
          r.clear_box = 1'b1;
        end else if (box_mode == ptw_pkg::MODE_FINAL) begin
          box_mode = ptw_pkg::MODE_IDLE;
        end
      end
    endcase
    r.mode = box_mode;
    return r;
  endfunction

  // Offer one item, wait for its transaction, then maybe open an idle gap.
  task automatic send_item(ptw_pkg::op_t op, logic [7:0] code, logic [7:0] x,
                           logic [7:0] y, logic w);
    ptw_pkg::item_t it;
    int gap;
    it.operation   = op;
    it.char_code   = code;
    it.start_x     = x;
    it.start_y     = y;
    it.wait_at_end = w;
    in_valid    <= 1'b1;
    operation   <= op;
    char_code   <= code;
    start_x     <= x;
    start_y     <= y;
    wait_at_end <= w;
    feeding = 1'b1;
    do @(posedge clk); while (!in_ready);
    tile_results_due.push_back(step_text_box(it));
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !steady_feed) begin
      burst_left = $urandom_range(20, 1);
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      feeding = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid once if it is still raised, then step past that edge.
  task automatic stop_feed();
    if (feeding) begin
      in_valid <= 1'b0;
      feeding = 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold until every result is back and the pipeline has emptied.
  task automatic wait_idle();
    stop_feed();
    while (tile_results_due.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no re-raise.
  task automatic write_reg(logic [7:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx[7:2] == 6'd0) begin
      case (idx[1:0])
        ptw_pkg::REG_LINES_PER_PAGE: lines_limit   = value;
        ptw_pkg::REG_GLYPH_OFFSET:   glyph_base    = value;
        ptw_pkg::REG_ARROW_COLUMN:   arrow_col_ofs = value;
        default:                     blank_tile    = value;
      endcase
    end
  endtask

  task automatic program_regs(logic [7:0] lpp, logic [7:0] ofs, logic [7:0] acol,
                              logic [7:0] btile);
    wait_idle();
    write_reg({6'd0, ptw_pkg::REG_LINES_PER_PAGE}, lpp);
    write_reg({6'd0, ptw_pkg::REG_GLYPH_OFFSET}, ofs);
    write_reg({6'd0, ptw_pkg::REG_ARROW_COLUMN}, acol);
    write_reg({6'd0, ptw_pkg::REG_BORDER_TILE}, btile);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed text sessions, steered by the predicted mode, plus noise.
  task automatic run_random_text(int target);
    int sent;
    int pick;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      case (box_mode)
        ptw_pkg::MODE_WRITING: begin
          if (pick < 68) begin
            send_item(ptw_pkg::OP_CHAR, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            sent++;
          end else if (pick < 84) begin
            send_item(ptw_pkg::OP_CHAR, ptw_pkg::CH_NEWLINE, rand_byte(), rand_byte(),
                      rand_bit());
            sent++;
          end else if (pick < 88) begin
            send_item(ptw_pkg::OP_CHAR, ptw_pkg::CH_END, rand_byte(), rand_byte(),
                      rand_bit());
            sent++;
          end else if (pick < 92) begin
            send_item(ptw_pkg::OP_BEGIN, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            sent++;
          end else if (pick < 96) begin
            send_item(ptw_pkg::OP_TICK, rand_byte(), rand_byte(), rand_byte(), rand_bit());
          end else begin
            send_item(ptw_pkg::OP_SELECT, rand_byte(), rand_byte(), rand_byte(), rand_bit());
          end
        end
        ptw_pkg::MODE_WAITING: begin
          if (pick < 88) begin
            send_item(ptw_pkg::OP_TICK, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            sent++;
          end else if (pick < 94) begin
            send_item(ptw_pkg::OP_SELECT, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            sent++;
          end else if (pick < 97) begin
            send_item(ptw_pkg::OP_CHAR, rand_byte(), rand_byte(), rand_byte(), rand_bit());
          end else begin
            send_item(ptw_pkg::OP_BEGIN, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            sent++;
          end
        end
        ptw_pkg::MODE_FINAL: begin
          if (pick < 40) begin
            send_item(ptw_pkg::OP_SELECT, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            sent++;
          end else if (pick < 60) begin
            send_item(ptw_pkg::OP_TICK, rand_byte(), rand_byte(), rand_byte(), rand_bit());
          end else if (pick < 85) begin
            send_item(ptw_pkg::OP_CHAR, rand_byte(), rand_byte(), rand_byte(), rand_bit());
          end else begin
            send_item(ptw_pkg::OP_BEGIN, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            sent++;
          end
        end
        default: begin
          if (pick < 70) begin
            send_item(ptw_pkg::OP_BEGIN, rand_byte(), rand_byte(), rand_byte(), rand_bit());
            sent++;
          end else begin
            send_item(ptw_pkg::op_t'(2'($urandom_range(3, 1))), rand_byte(),
                      rand_byte(), rand_byte(), rand_bit());
          end
        end
      endcase
    end
    stop_feed();
  endtask

  task automatic test_idle_refusals();
    send_item(ptw_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(ptw_pkg::OP_SELECT, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(ptw_pkg::OP_CHAR, CH_LETTER_A, 8'h00, 8'h00, 1'b0);
    stop_feed();
  endtask

  // Root at the highest corner so cursor and rows wrap at 8 bits.
  task automatic test_page_and_wrap();
    send_item(ptw_pkg::OP_BEGIN, 8'h00, 8'hFF, 8'hFE, 1'b1);
    send_item(ptw_pkg::OP_CHAR, 8'hFF, 8'h00, 8'h00, 1'b0);
    send_item(ptw_pkg::OP_CHAR, 8'h01, 8'h00, 8'h00, 1'b0);
    send_item(ptw_pkg::OP_CHAR, ptw_pkg::CH_NEWLINE, 8'h00, 8'h00, 1'b0);
    send_item(ptw_pkg::OP_CHAR, ptw_pkg::CH_NEWLINE, 8'h00, 8'h00, 1'b0);
    send_item(ptw_pkg::OP_CHAR, CH_LETTER_A, 8'h00, 8'h00, 1'b0);
    stop_feed();
  endtask

  // One full blink cycle, resume, end of text, leave the final wait.
  task automatic test_arrow_blink();
    repeat (16) send_item(ptw_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(ptw_pkg::OP_SELECT, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(ptw_pkg::OP_CHAR, ptw_pkg::CH_END, 8'h00, 8'h00, 1'b0);
    send_item(ptw_pkg::OP_SELECT, 8'h00, 8'h00, 8'h00, 1'b0);
    stop_feed();
  endtask

  task automatic test_backpressure();
    program_regs(8'd3, 8'd32, 8'd4, 8'd7);
    sink_style <= SINK_ALWAYS;
    steady_feed = 1'b1;
    -> long_stall_go;
    run_random_text(60);
    steady_feed = 1'b0;
  endtask

  task automatic test_random_pages();
    program_regs(8'd0, 8'd255, 8'd255, 8'd255);
    sink_style <= SINK_LIGHT;
    run_random_text(110);
    program_regs(8'd255, 8'd0, 8'd0, 8'd0);
    sink_style <= SINK_PERIODIC;
    run_random_text(110);
    program_regs(8'd1, 8'd32, rand_byte(), rand_byte());
    // An unmapped index must not disturb any register.
    write_reg(UNMAPPED_REG_INDEX, rand_byte());
    cfg_valid <= 1'b0;
    @(posedge clk);
    sink_style <= SINK_HEAVY;
    run_random_text(110);
    program_regs(8'($urandom_range(6, 1)), rand_byte(), rand_byte(), rand_byte());
    sink_style <= SINK_ALWAYS;
    steady_feed = 1'b1;
    run_random_text(110);
    steady_feed = 1'b0;
  endtask

  always begin
    @(long_stall_go);
    out_hold <= 1'b1;
    repeat (LONG_STALL_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  always @(posedge clk) begin
    sink_tick <= sink_tick + 8'd1;
    if (rst || out_hold) begin
      out_ready <= 1'b0;
    end else begin
      case (sink_style)
        SINK_ALWAYS:   out_ready <= 1'b1;
        SINK_LIGHT:    out_ready <= ($urandom_range(3) != 0);
        SINK_PERIODIC: out_ready <= (sink_tick[2:0] < 3'd5);
        default:       out_ready <= ($urandom_range(1) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    ptw_pkg::result_t got;
    ptw_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {write_valid, tile_x, tile_y, tile_index, clear_box, accepted, mode};
      if (got.write_valid) writes_seen++;
      if (got.clear_box) clears_seen++;
      if (!got.accepted) refusals_seen++;
      if (tile_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: wv=%0d x=%0d y=%0d idx=%0d clr=%0d acc=%0d mode=%0d",
                   got.write_valid, got.tile_x, got.tile_y, got.tile_index,
                   got.clear_box, got.accepted, got.mode);
      end else begin
        want = tile_results_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected wv=%0d x=%0d y=%0d idx=%0d clr=%0d acc=%0d mode=%0d",
                     want.write_valid, want.tile_x, want.tile_y, want.tile_index,
                     want.clear_box, want.accepted, want.mode);
            $display("          actual   wv=%0d x=%0d y=%0d idx=%0d clr=%0d acc=%0d mode=%0d",
                     got.write_valid, got.tile_x, got.tile_y, got.tile_index,
                     got.clear_box, got.accepted, got.mode);
          end
        end
      end
    end
  end

  initial begin
    lines_limit   = ptw_pkg::LINES_PER_PAGE_RST;
    glyph_base    = ptw_pkg::GLYPH_OFFSET_RST;
    arrow_col_ofs = ptw_pkg::ARROW_COLUMN_RST;
    blank_tile    = ptw_pkg::BORDER_TILE_RST;
    box_mode      = ptw_pkg::MODE_IDLE;
    cur_col       = '0;
    cur_row       = '0;
    home_col      = '0;
    home_row      = '0;
    page_lines    = '0;
    blink_phase   = '0;
    hold_at_end   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sink_style <= SINK_LIGHT;
    test_idle_refusals();
    test_page_and_wrap();
    test_arrow_blink();
    test_backpressure();
    test_random_pages();
    wait_idle();
    repeat (RESULT_LATENCY + 8) @(posedge clk);
    $display("covered %0d items: %0d tile writes, %0d box clears, %0d refused characters",
             items_sent, writes_seen, clears_seen, refusals_seen);
    $display("config extremes, wrap at 8 bits, blink cycle and a %0d-cycle output stall",
             LONG_STALL_CYCLES);
    if (mismatch_count == 0 && tile_results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", tile_results_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hdl/ptw_pkg.sv
hdl/ptw_step.sv
hdl/paged_text_tile_writer.sv
test/tb_paged_text_tile_writer.sv
